// ----- rtl/tpot_pkg.sv -----
package tpot_pkg;

    localparam int MAX_CONNECTIONS = 16;
    localparam int IDX_W = $clog2(MAX_CONNECTIONS);

    typedef logic [IDX_W-1:0] t_idx;

    // connection phases as stored in the table
    localparam logic [1:0] PH_SYN_RCVD    = 2'd1;
    localparam logic [1:0] PH_ESTABLISHED = 2'd2;
    localparam logic [1:0] PH_CLOSE_WAIT  = 2'd3;

    // bit positions in the tcp flag byte
    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_ACK = 4;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_SYN_REPLY = 2'd1,
        ACT_FIN_REPLY = 2'd2,
        ACT_DROP      = 2'd3
    } t_action;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dest_ip;
        logic [15:0] peer_port;
        logic [15:0] host_port;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [1:0]  phase;
        logic [31:0] local_seq;
        logic [31:0] remote_seq;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_key        key;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [31:0] iss;
    } t_seg;

    typedef struct packed {
        t_action     action;
        logic [15:0] from_port;
        logic [15:0] to_port;
        logic [31:0] seq;
        logic [31:0] ack;
    } t_rep;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic last_addr;
        logic out_busy;
    } t_sts;

endpackage

// ----- rtl/tpot_if.sv -----
interface tpot_seg_if;
    logic        valid;
    logic        ready;
    logic [31:0] seg_src_ip;
    logic [31:0] seg_dest_ip;
    logic [15:0] seg_src_port;
    logic [15:0] seg_dest_port;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [7:0]  seg_flags;
    logic [31:0] initial_seq;

    modport source (
        output valid, seg_src_ip, seg_dest_ip, seg_src_port, seg_dest_port,
               seg_seq, seg_ack, seg_flags, initial_seq,
        input  ready
    );
    modport sink (
        input  valid, seg_src_ip, seg_dest_ip, seg_src_port, seg_dest_port,
               seg_seq, seg_ack, seg_flags, initial_seq,
        output ready
    );
endinterface

interface tpot_rep_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dest_port;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;

    modport source (
        output valid, action, reply_src_port, reply_dest_port, reply_seq, reply_ack,
        input  ready
    );
    modport sink (
        input  valid, action, reply_src_port, reply_dest_port, reply_seq, reply_ack,
        output ready
    );
endinterface

// ----- rtl/tcp_passive_open_tracker.sv -----
// channel   dir  handshake       word
// i_seg     in   valid / ready   4-tuple, seq, ack, flags, initial seq
// o_rep     out  valid / ready   action, reply ports, reply seq, reply ack
//
// one segment is handled as a scan of the whole table: one table read
// per cycle through the single read port of the entry memory, then compare drain,
// decide and write-back
// synchronous active-low reset clears the in-use bits and the control state
// the result sits in an output register; a new segment is taken while it waits,
// and only the write-back step stalls until that register is free
module tcp_passive_open_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpot_seg_if.sink    i_seg,
    tpot_rep_if.source  o_rep
);

    tpot_pkg::t_cmd w_cmd;
    tpot_pkg::t_sts w_sts;
    tpot_pkg::t_seg w_seg;
    tpot_pkg::t_rep w_rep;
    logic           w_in_ready;
    logic           w_out_valid;

    assign w_seg.key.src_ip    = i_seg.seg_src_ip;
    assign w_seg.key.dest_ip   = i_seg.seg_dest_ip;
    assign w_seg.key.peer_port = i_seg.seg_src_port;
    assign w_seg.key.host_port = i_seg.seg_dest_port;
    assign w_seg.seq           = i_seg.seg_seq;
    assign w_seg.ack           = i_seg.seg_ack;
    assign w_seg.flags         = i_seg.seg_flags;
    assign w_seg.iss           = i_seg.initial_seq;

    tpot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_seg.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tpot_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_seg       (w_seg),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rep.ready),
        .o_out       (w_rep)
    );

    assign i_seg.ready           = w_in_ready;
    assign o_rep.valid           = w_out_valid;
    assign o_rep.action          = w_rep.action;
    assign o_rep.reply_src_port  = w_rep.from_port;
    assign o_rep.reply_dest_port = w_rep.to_port;
    assign o_rep.reply_seq       = w_rep.seq;
    assign o_rep.reply_ack       = w_rep.ack;

endmodule

// ----- rtl/tpot_ram.sv -----
module tpot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tpot_ctrl.sv -----
module tpot_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tpot_pkg::t_sts i_sts,
    output tpot_pkg::t_cmd o_cmd
);

    tpot_pkg::t_state r_state;
    tpot_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpot_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tpot_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tpot_pkg::ST_SCAN;
                end
            end
            tpot_pkg::ST_SCAN: begin
                if (i_sts.last_addr) begin
                    n_state = tpot_pkg::ST_DRAIN;
                end
            end
            tpot_pkg::ST_DRAIN: begin
                n_state = tpot_pkg::ST_DECIDE;
            end
            tpot_pkg::ST_DECIDE: begin
                // hold until the result register is free
                if (!i_sts.out_busy) begin
                    n_state = tpot_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tpot_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            tpot_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            tpot_pkg::ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            tpot_pkg::ST_DRAIN: begin
            end
            tpot_pkg::ST_DECIDE: begin
                o_cmd.commit = !i_sts.out_busy;
            end
            default: begin
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == tpot_pkg::ST_SCAN)
        else $error("accepted word did not start a scan");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpot_pkg::ST_SCAN && i_sts.last_addr) |=> r_state == tpot_pkg::ST_DRAIN)
        else $error("scan did not end after the last address");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == tpot_pkg::ST_IDLE && o_in_ready))
        else $error("controller not ready after commit");

endmodule

// ----- rtl/tpot_dp.sv -----
module tpot_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tpot_pkg::t_cmd i_cmd,
    output tpot_pkg::t_sts o_sts,
    input  tpot_pkg::t_seg i_seg,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tpot_pkg::t_rep o_out
);

    tpot_pkg::t_seg   r_seg;
    tpot_pkg::t_idx   r_scan_idx;
    tpot_pkg::t_idx   r_rd_idx;
    logic             r_rd_vld;
    logic             r_valid [tpot_pkg::MAX_CONNECTIONS];
    logic             r_hit;
    tpot_pkg::t_idx   r_hit_idx;
    tpot_pkg::t_entry r_hit_ent;
    logic             r_free;
    tpot_pkg::t_idx   r_free_idx;
    logic             r_out_valid;
    tpot_pkg::t_rep   r_out;

    tpot_pkg::t_rep   n_out;
    tpot_pkg::t_entry w_rd_ent;
    tpot_pkg::t_entry w_wdata;
    tpot_pkg::t_idx   w_waddr;
    logic             w_we;
    logic             w_set_valid;
    logic             w_match;
    logic             w_empty;
    logic [31:0]      w_local_inc;
    logic [31:0]      w_remote_inc;

    tpot_ram #(
        .WIDTH (tpot_pkg::ENTRY_W),
        .DEPTH (tpot_pkg::MAX_CONNECTIONS)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_scan_idx),
        .o_rdata (w_rd_ent)
    );

    // compare stage, one entry per cycle behind the read
    assign w_match = r_rd_vld && r_valid[r_rd_idx] && (w_rd_ent.key == r_seg.key);
    assign w_empty = r_rd_vld && !r_valid[r_rd_idx];

    assign o_sts.last_addr = r_scan_idx == tpot_pkg::t_idx'(tpot_pkg::MAX_CONNECTIONS - 1);
    assign o_sts.out_busy  = r_out_valid;

    assign w_local_inc  = r_hit_ent.local_seq + 32'd1;
    assign w_remote_inc = r_hit_ent.remote_seq + 32'd1;

    always_comb begin
        w_we        = 1'b0;
        w_set_valid = 1'b0;
        w_waddr     = r_hit_idx;
        w_wdata     = r_hit_ent;
        n_out       = '0;
        n_out.action = tpot_pkg::ACT_NONE;
        if (!r_hit) begin
            if (r_seg.flags[tpot_pkg::FLAG_SYN]) begin
                if (r_free) begin
                    w_we                = 1'b1;
                    w_set_valid         = 1'b1;
                    w_waddr             = r_free_idx;
                    w_wdata.key         = r_seg.key;
                    w_wdata.phase       = tpot_pkg::PH_SYN_RCVD;
                    w_wdata.local_seq   = r_seg.iss;
                    w_wdata.remote_seq  = r_seg.seq + 32'd1;
                    n_out.action        = tpot_pkg::ACT_SYN_REPLY;
                    n_out.from_port     = r_seg.key.host_port;
                    n_out.to_port       = r_seg.key.peer_port;
                    n_out.seq           = r_seg.iss;
                    n_out.ack           = r_seg.seq + 32'd1;
                end else begin
                    n_out.action = tpot_pkg::ACT_DROP;
                end
            end
        end else begin
            case (r_hit_ent.phase)
                tpot_pkg::PH_SYN_RCVD: begin
                    if (r_seg.flags[tpot_pkg::FLAG_ACK] && r_seg.ack == w_local_inc) begin
                        w_we              = 1'b1;
                        w_wdata.local_seq = w_local_inc;
                        w_wdata.phase     = tpot_pkg::PH_ESTABLISHED;
                    end
                end
                tpot_pkg::PH_ESTABLISHED: begin
                    if (r_seg.flags[tpot_pkg::FLAG_FIN]) begin
                        w_we               = 1'b1;
                        w_wdata.remote_seq = w_remote_inc;
                        w_wdata.phase      = tpot_pkg::PH_CLOSE_WAIT;
                        n_out.action       = tpot_pkg::ACT_FIN_REPLY;
                        n_out.from_port    = r_hit_ent.key.host_port;
                        n_out.to_port      = r_hit_ent.key.peer_port;
                        n_out.seq          = r_hit_ent.local_seq;
                        n_out.ack          = w_remote_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx  <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < tpot_pkg::MAX_CONNECTIONS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.accept) begin
                r_scan_idx <= '0;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
            end else begin
                if (i_cmd.rd_en) begin
                    r_scan_idx <= r_scan_idx + tpot_pkg::t_idx'(1);
                end
                if (w_match) begin
                    r_hit <= 1'b1;
                end
                if (w_empty) begin
                    r_free <= 1'b1;
                end
            end
            if (i_cmd.commit && w_set_valid) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_seg <= i_seg;
        end
        r_rd_idx <= r_scan_idx;
        // keep only the first match and the lowest free entry
        if (w_match && !r_hit) begin
            r_hit_idx <= r_rd_idx;
            r_hit_ent <= w_rd_ent;
        end
        if (w_empty && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !r_out_valid)
        else $error("result register overwritten");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> r_valid[r_hit_idx])
        else $error("hit on an entry that is not in use");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_set_valid) |=> r_valid[$past(r_free_idx)])
        else $error("inserted entry not marked in use");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.action == tpot_pkg::ACT_NONE
                         || r_out.action == tpot_pkg::ACT_DROP))
        |-> (r_out.from_port == '0 && r_out.to_port == '0
             && r_out.seq == '0 && r_out.ack == '0))
        else $error("reply fields not cleared without a reply");

endmodule
